/* src/btc_one_bit_audio_encoder_assert.svh */
// ----------------------------------------------------------------------------
// BTC encoder assertion macros
// Concurrent check macros. They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BTC_ONE_BIT_AUDIO_ENCODER_ASSERT_SVH
`define BTC_ONE_BIT_AUDIO_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent holds in the same cycle as the consequent
`define BTC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// consequent holds in the cycle after the antecedent
`define BTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BTC_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define BTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* src/btc_pkg.sv */
// ----------------------------------------------------------------------------
// BTC encoder package
// Widths, constants, register indexes and shared types of the encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int BYTE_W   = 8;
  localparam int VOLT_W   = 16;   // holds 0..32768
  localparam int TGT_W    = 17;   // signed target
  localparam int AIM_W    = 18;   // signed aim (midpoint or target)
  localparam int DIFF_W   = 19;   // signed step-to-aim distance
  localparam int SHIFT_W  = 4;
  localparam int IDX_W    = 2;
  localparam int CFG_W    = 8;

  localparam logic [VOLT_W:0]    V_FULL     = 17'd32768;
  localparam logic [VOLT_W-1:0]  V_RESET    = 16'd8192;
  localparam logic [TGT_W-1:0]   TGT_OFFSET = 17'd8192;
  localparam logic [BYTE_W-1:0]  FILL_UP    = 8'h55;
  localparam logic [BYTE_W-1:0]  FILL_DOWN  = 8'hAA;

  // register indexes
  localparam logic [IDX_W-1:0] REG_STEP_SHIFT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_SAMPLE_SHIFT = 2'd1;
  localparam logic [IDX_W-1:0] REG_OUT_MASK     = 2'd2;

  localparam logic [SHIFT_W-1:0] STEP_SHIFT_RST   = 4'd9;
  localparam logic [SHIFT_W-1:0] SAMPLE_SHIFT_RST = 4'd3;
  localparam logic [BYTE_W-1:0]  OUT_MASK_RST     = 8'hFF;

  typedef struct packed {
    logic [SHIFT_W-1:0] step_shift;
    logic [SHIFT_W-1:0] sample_shift;
    logic [BYTE_W-1:0]  out_mask;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_sample;  // capture sample, form target and midpoint
    logic step;         // decide one output bit
    logic first_bit;    // step is bit 0 of a byte
    logic even_bit;     // step is at an even bit position
    logic sel_target;   // aim at the target (second byte)
    logic out_load;     // move finished bytes into the output register
  } cmd_t;

endpackage

`default_nettype wire

/* src/btc_sample_if.sv */
// ----------------------------------------------------------------------------
// BTC sample channel
// Valid/ready channel carrying one signed PCM sample per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface btc_sample_if;
  import btc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* src/btc_result_if.sv */
// ----------------------------------------------------------------------------
// BTC result channel
// Valid/ready channel carrying the two pulse bytes of one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface btc_result_if;
  import btc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;

  modport source (output valid, output first_byte, output second_byte, input ready);
  modport sink   (input valid, input first_byte, input second_byte, output ready);
endinterface

`default_nettype wire

/* src/btc_one_bit_audio_encoder.sv */
// ----------------------------------------------------------------------------
// One-bit BTC audio encoder
// Turns each PCM sample into two bytes of 1-bit RC-filter pulses.
// ----------------------------------------------------------------------------
//   channel    dir  payload                      handshake
//   sample_ch  in   sample (s16)                 valid/ready
//   result_ch  out  first_byte, second_byte (u8) valid/ready
//   cfg        in   cfg_index, cfg_data          cfg_wr_en, no wait
//
// Each item runs through accept, 16 bit decisions (one per cycle through
// the single step/compare unit) and the output register load.
// A finished result waits in the output register; the next sample is taken
// meanwhile and only the final load waits for the register to empty.
// Reset: voltage 8192, step_shift 9, sample_shift 3, out_mask 0xFF.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "btc_one_bit_audio_encoder_assert.svh"

module btc_one_bit_audio_encoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  btc_sample_if.sink                       sample_ch,
  btc_result_if.source                     result_ch,
  input  wire logic                        cfg_wr_en,
  input  wire logic [btc_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [btc_pkg::CFG_W-1:0]   cfg_data
);
  import btc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_shift   <= STEP_SHIFT_RST;
      cfg.sample_shift <= SAMPLE_SHIFT_RST;
      cfg.out_mask     <= OUT_MASK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_STEP_SHIFT:   cfg.step_shift   <= cfg_data[SHIFT_W-1:0];
        REG_SAMPLE_SHIFT: cfg.sample_shift <= cfg_data[SHIFT_W-1:0];
        REG_OUT_MASK:     cfg.out_mask     <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  btc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .cmd       (cmd)
  );

  btc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sample      (sample_ch.sample),
    .first_byte  (result_ch.first_byte),
    .second_byte (result_ch.second_byte)
  );

  // checks
  `BTC_ASSERT_NEXT(a_busy_after_accept, clk, rst, sample_ch.valid && sample_ch.ready, !sample_ch.ready, "ready after accept")
  `BTC_ASSERT_NEXT(a_load_gives_valid, clk, rst, cmd.out_load, result_ch.valid, "no valid after load")
  `BTC_ASSERT_SAME(a_no_step_when_idle, clk, rst, sample_ch.ready, !cmd.step && !cmd.out_load, "step while idle")

endmodule

`default_nettype wire

/* src/btc_ctrl.sv */
// ----------------------------------------------------------------------------
// BTC encoder controller
// Sequences one item: accept, sixteen bit decisions, hand-off to output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output btc_pkg::cmd_t      cmd
);
  import btc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE1,
    S_BYTE2,
    S_PUT
  } state_t;

  state_t     state;
  logic [2:0] pos;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd             = '0;
    cmd.load_sample = (state == S_IDLE) && in_valid;
    cmd.step        = (state == S_BYTE1) || (state == S_BYTE2);
    cmd.first_bit   = (pos == 3'd0);
    cmd.even_bit    = !pos[0];
    cmd.sel_target  = (state == S_BYTE2);
    cmd.out_load    = (state == S_PUT) && out_free;
  end

  // state, bit counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          pos <= 3'd0;
          if (in_valid) state <= S_BYTE1;
        end
        S_BYTE1: begin
          pos <= pos + 3'd1;
          if (pos == 3'd7) state <= S_BYTE2;
        end
        S_BYTE2: begin
          pos <= pos + 3'd1;
          if (pos == 3'd7) state <= S_PUT;
        end
        S_PUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // valid set on load, cleared once the item is taken
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* src/btc_datapath.sv */
// ----------------------------------------------------------------------------
// BTC encoder datapath
// RC voltage model, aim registers, bit decision and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire btc_pkg::cfg_t                 cfg,
  input  wire btc_pkg::cmd_t                 cmd,
  input  wire logic signed [btc_pkg::SAMPLE_W-1:0] sample,
  output logic [btc_pkg::BYTE_W-1:0]         first_byte,
  output logic [btc_pkg::BYTE_W-1:0]         second_byte
);
  import btc_pkg::*;

  logic [VOLT_W-1:0]        volt;
  logic                     hold;
  logic                     fill;
  logic signed [TGT_W-1:0]  tgt;
  logic signed [AIM_W-1:0]  mid;
  logic [2*BYTE_W-1:0]      acc;

  logic signed [SAMPLE_W-1:0] shifted;
  logic signed [TGT_W-1:0]    tgt_next;
  logic signed [AIM_W-1:0]    sum;
  logic signed [AIM_W-1:0]    mid_next;

  logic signed [AIM_W-1:0]  aim;
  logic [VOLT_W:0]          rise;
  logic [VOLT_W:0]          up_w;
  logic [VOLT_W-1:0]        up;
  logic [VOLT_W-1:0]        down;
  logic signed [DIFF_W-1:0] du;
  logic signed [DIFF_W-1:0] dd;
  logic [DIFF_W-1:0]        mag_u;
  logic [DIFF_W-1:0]        mag_d;
  logic                     closer_up;
  logic                     between;
  logic                     holding;
  logic                     bit_out;

  // target and midpoint from the new sample (midpoint truncates toward zero)
  always_comb begin
    shifted  = sample >>> cfg.sample_shift;
    tgt_next = {shifted[SAMPLE_W-1], shifted} + $signed(TGT_OFFSET);
    sum      = $signed({2'b00, volt}) + {tgt_next[TGT_W-1], tgt_next};
    mid_next = (sum >>> 1) + $signed({{(AIM_W-1){1'b0}}, sum[AIM_W-1] & sum[0]});
  end

  // up/down steps and their distance to the aim
  always_comb begin
    aim       = cmd.sel_target ? {tgt[TGT_W-1], tgt} : mid;
    rise      = (V_FULL - {1'b0, volt}) >> cfg.step_shift;
    up_w      = {1'b0, volt} + rise;
    up        = up_w[VOLT_W-1:0];
    down      = volt - (volt >> cfg.step_shift);
    du        = $signed({3'b000, up}) - {aim[AIM_W-1], aim};
    dd        = $signed({3'b000, down}) - {aim[AIM_W-1], aim};
    mag_u     = du[DIFF_W-1] ? -du : du;
    mag_d     = dd[DIFF_W-1] ? -dd : dd;
    closer_up = mag_u < mag_d;
    between   = cmd.even_bit && !du[DIFF_W-1] && (du != '0) && dd[DIFF_W-1];
    holding   = hold && !cmd.first_bit;
    bit_out   = holding ? fill : closer_up;
  end

  // voltage and hold-pattern state
  always_ff @(posedge clk) begin
    if (rst) begin
      volt <= V_RESET;
      hold <= 1'b0;
      fill <= 1'b0;
    end else if (cmd.step) begin
      if (holding) begin
        fill <= ~fill;
      end else if (between) begin
        // 0x55 fill when up is closer, 0xAA otherwise, from the LSB upward
        hold <= 1'b1;
        fill <= closer_up ? FILL_UP[1] : FILL_DOWN[1];
      end else begin
        hold <= 1'b0;
        volt <= closer_up ? up : down;
      end
    end
  end

  // aim registers, bit accumulator and output register
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      tgt <= tgt_next;
      mid <= mid_next;
    end
    if (cmd.step) acc <= {acc[2*BYTE_W-2:0], bit_out};
    if (cmd.out_load) begin
      first_byte  <= acc[2*BYTE_W-1:BYTE_W] & cfg.out_mask;
      second_byte <= acc[BYTE_W-1:0] & cfg.out_mask;
    end
  end

endmodule

`default_nettype wire

/* sim/btc_pulse_checker.sv */
// ----------------------------------------------------------------------------
// BTC encoder pulse checker
// Watches the sample, result and register ports of the encoder, works out
// the two pulse bytes of every accepted sample from its own copy of the RC
// voltage and registers, and compares them in order with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btc_pulse_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  btc_sample_if                          smp,
  btc_result_if                          res,
  input  wire logic                      cfg_wr_en,
  input  wire logic [btc_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [btc_pkg::CFG_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);
  import btc_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
  } pulse_pair_t;

  pulse_pair_t       pulse_q[$];
  int                volt;
  logic [SHIFT_W-1:0] step_sh;
  logic [SHIFT_W-1:0] sample_sh;
  logic [BYTE_W-1:0]  mask;
  int                mismatches;
  int                n_checked;

  // steer the voltage toward aim for one byte, MSB first
  function automatic logic [BYTE_W-1:0] steer_byte(input int aim);
    logic [BYTE_W-1:0] bits;
    logic [BYTE_W-1:0] fill;
    int                up_v;
    int                down_v;
    int                dist_up;
    int                dist_down;
    bit                held;
    bits = '0;
    fill = '0;
    held = 1'b0;
    for (int pos = 0; pos < BYTE_W; pos++) begin
      if (!held) begin
        up_v   = volt + ((int'(V_FULL) - volt) >> step_sh);
        down_v = volt - (volt >> step_sh);
        // aim trapped between the steps on an even bit: hold pattern
        if (pos % 2 == 0 && up_v > aim && down_v < aim) begin
          held = 1'b1;
          fill = (up_v - aim < aim - down_v) ? FILL_UP : FILL_DOWN;
        end
      end
      if (held) begin
        bits = {bits[BYTE_W-2:0], fill[0]};
        fill = fill >> 1;
      end else begin
        dist_up   = (up_v > aim) ? up_v - aim : aim - up_v;
        dist_down = (down_v > aim) ? down_v - aim : aim - down_v;
        // a tie goes down
        if (dist_up < dist_down) begin
          bits = {bits[BYTE_W-2:0], 1'b1};
          volt = up_v;
        end else begin
          bits = {bits[BYTE_W-2:0], 1'b0};
          volt = down_v;
        end
      end
    end
    return bits & mask;
  endfunction

  always @(posedge clk) begin
    pulse_pair_t want;
    int          target;
    int          mid;
    if (rst) begin
      volt       = int'(V_RESET);
      step_sh    = STEP_SHIFT_RST;
      sample_sh  = SAMPLE_SHIFT_RST;
      mask       = OUT_MASK_RST;
      mismatches = 0;
      n_checked  = 0;
      pulse_q.delete();
    end else begin
      // register writes; a spare index is ignored
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_STEP_SHIFT:   step_sh   = cfg_data[SHIFT_W-1:0];
          REG_SAMPLE_SHIFT: sample_sh = cfg_data[SHIFT_W-1:0];
          REG_OUT_MASK:     mask      = cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end

      // results leaving the block
      if (res.valid && res.ready) begin
        if (pulse_q.size() == 0) begin
          $display("%0t: result with nothing outstanding, got %02h %02h",
                   $time, res.first_byte, res.second_byte);
          mismatches++;
        end else begin
          want = pulse_q.pop_front();
          n_checked++;
          if (res.first_byte !== want.first_byte) begin
            $display("%0t: first_byte mismatch, expected %02h, got %02h",
                     $time, want.first_byte, res.first_byte);
            mismatches++;
          end
          if (res.second_byte !== want.second_byte) begin
            $display("%0t: second_byte mismatch, expected %02h, got %02h",
                     $time, want.second_byte, res.second_byte);
            mismatches++;
          end
        end
      end

      // samples entering the block
      if (smp.valid && smp.ready) begin
        target = (int'(smp.sample) >>> sample_sh) + int'(TGT_OFFSET);
        mid    = (volt + target) / 2;
        want.first_byte  = steer_byte(mid);
        want.second_byte = steer_byte(target);
        pulse_q.push_back(want);
      end
    end
    fail_count <= mismatches;
    pending    <= pulse_q.size();
    checked    <= n_checked;
  end

endmodule

/* sim/tb_btc_one_bit_audio_encoder.sv */
// ----------------------------------------------------------------------------
// BTC encoder testbench
// Drives PCM samples and register settings into the encoder with random
// idling on both channels and one long output stall, while the pulse checker
// compares every pulse pair against its own prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_btc_one_bit_audio_encoder;
  import btc_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 180;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int sent_count     = 0;
  int settings_count = 0;
  int cycle_count    = 0;
  bit idle_on        = 1'b0;
  bit long_hold      = 1'b0;

  // edge values under the reset settings, hold pattern both ways included
  logic signed [SAMPLE_W-1:0] reset_cfg_samples [13] = '{
    16'sd0, 16'sd0, 16'sd8, 16'sd304, -16'sd304, 16'sd32767, -16'sd32768,
    16'sd32767, -16'sd32768, -16'sd1, 16'sd1, 16'sd21845, -16'sd21846
  };
  // with no sample shift these push the target past both rails
  logic signed [SAMPLE_W-1:0] rail_samples [6] = '{
    16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd0, 16'sd16384
  };

  btc_sample_if sample_ch ();
  btc_result_if result_ch ();

  btc_one_bit_audio_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  btc_pulse_checker pulse_chk (
    .clk        (clk),
    .rst        (rst),
    .smp        (sample_ch),
    .res        (result_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("btc_one_bit_audio_encoder regression: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // offer one sample, with an occasional gap first
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk); while (!sample_ch.ready);
    sent_count++;
  endtask

  // wait for the block to drain, then write all registers plus the spare index
  task automatic retune(input logic [SHIFT_W-1:0] st, input logic [SHIFT_W-1:0] sh,
                        input logic [BYTE_W-1:0] mk);
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_STEP_SHIFT;
    cfg_data  <= {4'($urandom_range(0, 15)), st};
    @(posedge clk);
    cfg_index <= REG_SAMPLE_SHIFT;
    cfg_data  <= {4'($urandom_range(0, 15)), sh};
    @(posedge clk);
    cfg_index <= REG_OUT_MASK;
    cfg_data  <= mk;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= 8'($urandom_range(0, 255));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_count++;
  endtask

  // one register setting followed by a stream of random samples
  task automatic run_phase(input logic [SHIFT_W-1:0] st, input logic [SHIFT_W-1:0] sh,
                           input logic [BYTE_W-1:0] mk, input bit with_idle,
                           input bit with_hold);
    logic signed [SAMPLE_W-1:0] value;
    logic signed [SAMPLE_W-1:0] last_value;
    retune(st, sh, mk);
    idle_on = with_idle;
    if (with_hold) long_hold = 1'b1;
    last_value = '0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: value = 16'($urandom);
        4, 5, 6:    value = 16'($urandom_range(0, 1023) - 512);
        7:          value = 16'($urandom_range(0, 31) - 16);
        8:          value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        // repeats let the voltage settle onto the target and hold
        default:    value = last_value;
      endcase
      send_sample(value);
      last_value = value;
    end
  endtask

  initial begin
    rst              <= 1'b1;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= REG_STEP_SHIFT;
    cfg_data         <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed items, reset settings first
    foreach (reset_cfg_samples[i]) send_sample(reset_cfg_samples[i]);
    retune(4'd4, 4'd0, 8'hFF);
    foreach (rail_samples[i]) send_sample(rail_samples[i]);

    // random phases over a spread of settings
    run_phase(STEP_SHIFT_RST, SAMPLE_SHIFT_RST, OUT_MASK_RST, 1'b1, 1'b0);
    run_phase(4'd0, 4'd0, 8'hFF, 1'b1, 1'b0);
    run_phase(4'd15, 4'd15, 8'hFF, 1'b1, 1'b0);
    run_phase(4'd5, 4'd2, 8'h5A, 1'b0, 1'b1);
    run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 8'h00, 1'b1, 1'b0);
    run_phase(4'd12, 4'd4, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
    run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              8'($urandom_range(0, 255)), 1'b1, 1'b0);
    // closing stretch without idling
    run_phase(4'd9, 4'd3, 8'hFF, 1'b0, 1'b0);
    sample_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples over %0d register settings, %0d pulse pairs compared",
             sent_count, settings_count, checked);
    $display("%0d mismatches, %0d results still outstanding", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("btc_one_bit_audio_encoder regression: pass");
    end else begin
      $display("btc_one_bit_audio_encoder regression: fail");
    end
    $finish;
  end

endmodule

/* btc_one_bit_audio_encoder.f */
+incdir+src
src/btc_pkg.sv
src/btc_sample_if.sv
src/btc_result_if.sv
src/btc_ctrl.sv
src/btc_datapath.sv
src/btc_one_bit_audio_encoder.sv
sim/btc_pulse_checker.sv
sim/tb_btc_one_bit_audio_encoder.sv
